// ===== sv/i2cm_pkg.sv =====
// Shared types, codes and constants of the I2C master bit engine.
package i2cm_pkg;

   localparam int unsigned HALF_W    = 16;
   localparam int unsigned STRETCH_W = 10;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned BIT_CNT_W = 4;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [BIT_CNT_W-1:0] DATA_BITS     = 4'd8;
   localparam logic [HALF_W-1:0]    HALF_RESET    = 16'd250;
   localparam logic [STRETCH_W-1:0] STRETCH_RESET = 10'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_PERIOD = 1'b0,
      CSR_STRETCH     = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   typedef enum logic [4:0] {
      PH_IDLE     = 5'd0,
      PH_RS_REL   = 5'd1,
      PH_RS_WAIT  = 5'd2,
      PH_RS_SETUP = 5'd3,
      PH_ST_CHK   = 5'd4,
      PH_ST_HOLD  = 5'd5,
      PH_SP_LOW   = 5'd6,
      PH_SP_WAIT  = 5'd7,
      PH_SP_SETUP = 5'd8,
      PH_SP_REL   = 5'd9,
      PH_SP_END   = 5'd10,
      PH_WR_LOW   = 5'd11,
      PH_WR_WAIT  = 5'd12,
      PH_WR_HIGH  = 5'd13,
      PH_RD_LOW   = 5'd14,
      PH_RD_WAIT  = 5'd15,
      PH_RD_HIGH  = 5'd16,
      PH_RN_LOW   = 5'd17,
      PH_RN_WAIT  = 5'd18,
      PH_RN_HIGH  = 5'd19
   } phase_type;

   typedef struct packed {
      logic [HALF_W-1:0]    half_period_ticks;
      logic [STRETCH_W-1:0] stretch_limit;
   } cfg_type;

   typedef struct packed {
      logic              scl_drive_low;
      logic              sda_drive_low;
      logic              ready_res;
      logic              done_res;
      logic [BYTE_W-1:0] read_data;
      logic              acked;
      logic              arbitration_lost;
      logic              bus_started;
   } res_type;

   function automatic logic is_wait(input phase_type p);
      return p == PH_RS_WAIT || p == PH_SP_WAIT || p == PH_WR_WAIT ||
             p == PH_RD_WAIT || p == PH_RN_WAIT;
   endfunction

endpackage

// ===== sv/i2cm_core.sv =====
// Bus phase sequencer: phase, counters, shift byte and flags, advanced one tick per beat.
module i2cm_core import i2cm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [2:0]           cmd,
   input  logic [BYTE_W-1:0]    write_data,
   input  logic                 send_nack,
   input  logic                 scl_in,
   input  logic                 sda_in,
   input  cfg_type              cfg,
   output res_type              res
);

   phase_type              phase_ff, phase_in;
   logic [BIT_CNT_W-1:0]   bit_ff, bit_in;
   logic [BYTE_W-1:0]      shift_ff, shift_in;
   logic [HALF_W-1:0]      delay_ff, delay_in;
   logic [STRETCH_W-1:0]   stretch_ff, stretch_in;
   logic [BYTE_W-1:0]      rdbyte_ff, rdbyte_in;
   logic                   started_ff, started_in;
   logic                   arb_ff, arb_in;
   logic                   ack_ff, ack_in;
   logic                   scl_low_ff, scl_low_in;
   logic                   sda_low_ff, sda_low_in;

   logic                   enter_en;
   phase_type              enter_ph;
   logic                   done;
   logic [HALF_W:0]        half;
   logic                   half_open;

   // a zero half period acts as one tick
   assign half      = (cfg.half_period_ticks == '0) ? {{HALF_W{1'b0}}, 1'b1}
                                                    : {1'b0, cfg.half_period_ticks};
   assign half_open = ({1'b0, delay_ff} + {{HALF_W{1'b0}}, 1'b1}) < half;

   always_comb begin
      phase_in   = phase_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      delay_in   = delay_ff;
      stretch_in = stretch_ff;
      rdbyte_in  = rdbyte_ff;
      started_in = started_ff;
      arb_in     = arb_ff;
      ack_in     = ack_ff;
      scl_low_in = scl_low_ff;
      sda_low_in = sda_low_ff;
      enter_en   = 1'b0;
      enter_ph   = phase_ff;
      done       = 1'b0;

      priority if (phase_ff == PH_IDLE) begin
         if (cmd == CMD_START || cmd == CMD_STOP || cmd == CMD_WRITE || cmd == CMD_READ) begin
            arb_in   = 1'b0;
            enter_en = 1'b1;
            priority if (cmd == CMD_START) begin
               enter_ph = started_ff ? PH_RS_REL : PH_ST_CHK;
            end else if (cmd == CMD_STOP) begin
               enter_ph = PH_SP_LOW;
            end else if (cmd == CMD_WRITE) begin
               shift_in = write_data;
               bit_in   = '0;
               enter_ph = PH_WR_LOW;
            end else begin
               shift_in = '0;
               bit_in   = '0;
               enter_ph = send_nack ? PH_RN_LOW : PH_RD_LOW;
            end
         end
      end else if (is_wait(phase_ff)) begin
         // hold while the slave stretches SCL, up to the limit
         if (scl_in || stretch_ff >= cfg.stretch_limit) begin
            enter_en = 1'b1;
            unique case (phase_ff)
               PH_RS_WAIT: enter_ph = PH_RS_SETUP;
               PH_SP_WAIT: enter_ph = PH_SP_SETUP;
               PH_WR_WAIT: enter_ph = PH_WR_HIGH;
               PH_RD_WAIT: enter_ph = PH_RD_HIGH;
               default:    enter_ph = PH_RN_HIGH;
            endcase
         end else begin
            stretch_in = stretch_ff + 1'b1;
         end
      end else if (half_open) begin
         delay_in = delay_ff + 1'b1;
      end else begin
         enter_en = 1'b1;
         unique case (phase_ff)
            PH_ST_CHK: begin
               if (!sda_in) arb_in = 1'b1;
               enter_ph = PH_ST_HOLD;
            end
            PH_ST_HOLD: begin
               scl_low_in = 1'b1;
               started_in = 1'b1;
               done       = 1'b1;
               enter_ph   = PH_IDLE;
            end
            PH_SP_REL: begin
               if (!sda_in) arb_in = 1'b1;
               enter_ph = PH_SP_END;
            end
            PH_SP_END: begin
               started_in = 1'b0;
               done       = 1'b1;
               enter_ph   = PH_IDLE;
            end
            PH_WR_HIGH: begin
               if (bit_ff < DATA_BITS) begin
                  if (shift_ff[BYTE_W-1] && !sda_in) arb_in = 1'b1;
                  shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
               end else begin
                  ack_in = !sda_in;
               end
               scl_low_in = 1'b1;
               if (bit_ff >= DATA_BITS) begin
                  done     = 1'b1;
                  enter_ph = PH_IDLE;
               end else begin
                  bit_in   = bit_ff + 1'b1;
                  enter_ph = PH_WR_LOW;
               end
            end
            PH_RD_HIGH, PH_RN_HIGH: begin
               if (bit_ff < DATA_BITS) begin
                  shift_in = {shift_ff[BYTE_W-2:0], sda_in};
               end else begin
                  if (phase_ff == PH_RN_HIGH && !sda_in) arb_in = 1'b1;
                  rdbyte_in = shift_ff;
               end
               scl_low_in = 1'b1;
               if (bit_ff >= DATA_BITS) begin
                  done     = 1'b1;
                  enter_ph = PH_IDLE;
               end else begin
                  bit_in   = bit_ff + 1'b1;
                  enter_ph = (phase_ff == PH_RN_HIGH) ? PH_RN_LOW : PH_RD_LOW;
               end
            end
            PH_RS_REL:   enter_ph = PH_RS_WAIT;
            PH_RS_SETUP: enter_ph = PH_ST_CHK;
            PH_SP_LOW:   enter_ph = PH_SP_WAIT;
            PH_SP_SETUP: enter_ph = PH_SP_REL;
            PH_WR_LOW:   enter_ph = PH_WR_WAIT;
            PH_RD_LOW:   enter_ph = PH_RD_WAIT;
            PH_RN_LOW:   enter_ph = PH_RN_WAIT;
            default:     enter_ph = PH_IDLE;
         endcase
      end

      // entering a phase restarts the counters and sets up the lines
      if (enter_en) begin
         phase_in   = enter_ph;
         delay_in   = '0;
         stretch_in = '0;
         if (is_wait(enter_ph)) begin
            scl_low_in = 1'b0;
         end else if (enter_ph == PH_RS_REL || enter_ph == PH_ST_CHK ||
                      enter_ph == PH_SP_REL || enter_ph == PH_RN_LOW) begin
            sda_low_in = 1'b0;
         end else if (enter_ph == PH_ST_HOLD || enter_ph == PH_SP_LOW) begin
            sda_low_in = 1'b1;
         end else if (enter_ph == PH_WR_LOW) begin
            sda_low_in = (bit_in < DATA_BITS) ? !shift_in[BYTE_W-1] : 1'b0;
         end else if (enter_ph == PH_RD_LOW) begin
            sda_low_in = (bit_in >= DATA_BITS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         bit_ff     <= '0;
         shift_ff   <= '0;
         delay_ff   <= '0;
         stretch_ff <= '0;
         rdbyte_ff  <= '0;
         started_ff <= 1'b0;
         arb_ff     <= 1'b0;
         ack_ff     <= 1'b0;
         scl_low_ff <= 1'b0;
         sda_low_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         delay_ff   <= delay_in;
         stretch_ff <= stretch_in;
         rdbyte_ff  <= rdbyte_in;
         started_ff <= started_in;
         arb_ff     <= arb_in;
         ack_ff     <= ack_in;
         scl_low_ff <= scl_low_in;
         sda_low_ff <= sda_low_in;
      end
   end

   always_comb begin
      res.scl_drive_low    = scl_low_in;
      res.sda_drive_low    = sda_low_in;
      res.ready_res        = (phase_in == PH_IDLE);
      res.done_res         = done;
      res.read_data        = rdbyte_in;
      res.acked            = ack_in;
      res.arbitration_lost = arb_in;
      res.bus_started      = started_in;
   end

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && done |=> phase_ff == PH_IDLE)
      else $error("command finished but sequencer not idle");

   a_start_src: assert property (@(posedge clock) disable iff (reset)
      $rose(started_ff) |-> $past(phase_ff) == PH_ST_HOLD)
      else $error("bus started without a start hold phase");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_IDLE && cmd == CMD_NONE |=> phase_ff == PH_IDLE)
      else $error("left idle without a command");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_WR_HIGH && bit_ff < DATA_BITS && !half_open
      |=> bit_ff == $past(bit_ff) + 1'b1)
      else $error("write bit count did not advance");

endmodule

// ===== sv/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: handshakes, configuration and result register.
//
// Each input beat is one bus tick carrying the sampled SCL and SDA levels and, when the
// engine reports ready, an optional command (start or repeated start, stop, write byte,
// read byte with ACK or NACK). Every beat yields exactly one result beat with the line
// drives and status after that tick, in the next cycle through a single result register.
// A beat is taken every cycle; the only throttle is back-pressure on the result side,
// which stalls the input while the result register is full and stalled. Each timed bus
// phase lasts half_period_ticks beats; a slave holding SCL low is waited on until
// stretch_limit stretch beats are counted. Configuration writes apply from the next cycle on.
module i2c_master_bit_engine import i2cm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_command,
   input  logic [BYTE_W-1:0]    req_write_data,
   input  logic                 req_send_nack,
   input  logic                 req_scl_in,
   input  logic                 req_sda_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_scl_drive_low,
   output logic                 rsp_sda_drive_low,
   output logic                 rsp_ready_res,
   output logic                 rsp_done_res,
   output logic [BYTE_W-1:0]    rsp_read_data,
   output logic                 rsp_acked,
   output logic                 rsp_arbitration_lost,
   output logic                 rsp_bus_started,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [HALF_W-1:0]    csr_wdata
);

   cfg_type   cfg_ff;
   res_type   res_next;
   res_type   res_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks <= HALF_RESET;
         cfg_ff.stretch_limit     <= STRETCH_RESET;
      end else if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            CSR_HALF_PERIOD: cfg_ff.half_period_ticks <= csr_wdata;
            CSR_STRETCH:     cfg_ff.stretch_limit     <= csr_wdata[STRETCH_W-1:0];
            default:         cfg_ff.stretch_limit     <= cfg_ff.stretch_limit;
         endcase
      end
   end

   i2cm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (accept),
      .cmd        (req_command),
      .write_data (req_write_data),
      .send_nack  (req_send_nack),
      .scl_in     (req_scl_in),
      .sda_in     (req_sda_in),
      .cfg        (cfg_ff),
      .res        (res_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the result beat on accept, hold it otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= res_next;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_scl_drive_low    = res_ff.scl_drive_low;
   assign rsp_sda_drive_low    = res_ff.sda_drive_low;
   assign rsp_ready_res        = res_ff.ready_res;
   assign rsp_done_res         = res_ff.done_res;
   assign rsp_read_data        = res_ff.read_data;
   assign rsp_acked            = res_ff.acked;
   assign rsp_arbitration_lost = res_ff.arbitration_lost;
   assign rsp_bus_started      = res_ff.bus_started;

endmodule

// ===== tb/sv/i2cm_bus_checker.sv =====
// Checker for the I2C master bit engine: per-tick bus predictor and result compare.
`timescale 1ns / 100ps

module i2cm_bus_checker import i2cm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [2:0]           req_command,
   input  logic [BYTE_W-1:0]    req_write_data,
   input  logic                 req_send_nack,
   input  logic                 req_scl_in,
   input  logic                 req_sda_in,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_scl_drive_low,
   input  logic                 rsp_sda_drive_low,
   input  logic                 rsp_ready_res,
   input  logic                 rsp_done_res,
   input  logic [BYTE_W-1:0]    rsp_read_data,
   input  logic                 rsp_acked,
   input  logic                 rsp_arbitration_lost,
   input  logic                 rsp_bus_started,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [HALF_W-1:0]    csr_wdata,
   output int unsigned          mismatch_count,
   output int unsigned          open_results
);

   logic [HALF_W-1:0]    cfg_half;
   logic [STRETCH_W-1:0] cfg_stretch;

   phase_type            bus_phase;
   logic [BIT_CNT_W-1:0] bit_idx;
   logic [BYTE_W-1:0]    shreg;
   logic [HALF_W-1:0]    hp_ticks;
   logic [STRETCH_W-1:0] stretch_ticks;
   logic [BYTE_W-1:0]    last_read;
   logic                 bus_owned;
   logic                 arb_lost;
   logic                 slave_ack;
   logic                 scl_pull;
   logic                 sda_pull;

   res_type expected_status[$];

   function automatic logic scl_wait_phase(input phase_type p);
      case (p)
         PH_RS_WAIT, PH_SP_WAIT, PH_WR_WAIT, PH_RD_WAIT, PH_RN_WAIT: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void enter_phase(input phase_type p);
      bus_phase     = p;
      hp_ticks      = '0;
      stretch_ticks = '0;
      case (p)
         PH_RS_WAIT, PH_SP_WAIT, PH_WR_WAIT, PH_RD_WAIT, PH_RN_WAIT: scl_pull = 1'b0;
         PH_RS_REL, PH_ST_CHK, PH_SP_REL, PH_RN_LOW: sda_pull = 1'b0;
         PH_ST_HOLD, PH_SP_LOW: sda_pull = 1'b1;
         PH_WR_LOW: sda_pull = (bit_idx < DATA_BITS) ? !shreg[BYTE_W-1] : 1'b0;
         PH_RD_LOW: sda_pull = (bit_idx >= DATA_BITS);
         default: ;
      endcase
   endfunction

   // SCL goes low at the end of a bit; the ninth bit ends the byte
   function automatic logic finish_bit(input phase_type low_phase);
      scl_pull = 1'b1;
      if (bit_idx >= DATA_BITS) begin
         enter_phase(PH_IDLE);
         return 1'b1;
      end
      bit_idx = bit_idx + 1'b1;
      enter_phase(low_phase);
      return 1'b0;
   endfunction

   function automatic res_type advance_bus_tick(input logic [2:0] cmd,
                                                input logic [BYTE_W-1:0] wdata,
                                                input logic nack,
                                                input logic scl,
                                                input logic sda);
      res_type     beat;
      logic        done;
      int unsigned half_eff;
      half_eff = (cfg_half == '0) ? 1 : 32'(cfg_half);
      done = 1'b0;
      if (bus_phase == PH_IDLE) begin
         if (cmd >= CMD_START && cmd <= CMD_READ) begin
            arb_lost = 1'b0;
            case (cmd)
               CMD_START: enter_phase(bus_owned ? PH_RS_REL : PH_ST_CHK);
               CMD_STOP: enter_phase(PH_SP_LOW);
               CMD_WRITE: begin
                  shreg   = wdata;
                  bit_idx = '0;
                  enter_phase(PH_WR_LOW);
               end
               default: begin
                  shreg   = '0;
                  bit_idx = '0;
                  enter_phase(nack ? PH_RN_LOW : PH_RD_LOW);
               end
            endcase
         end
      end else if (scl_wait_phase(bus_phase)) begin
         // wait out clock stretching, bounded by the limit
         if (scl || stretch_ticks >= cfg_stretch)
            enter_phase(phase_type'(bus_phase + 5'd1));
         else
            stretch_ticks = stretch_ticks + 1'b1;
      end else if (32'(hp_ticks) + 32'd1 < half_eff) begin
         hp_ticks = hp_ticks + 1'b1;
      end else begin
         case (bus_phase)
            PH_ST_CHK: begin
               if (!sda) arb_lost = 1'b1;
               enter_phase(PH_ST_HOLD);
            end
            PH_ST_HOLD: begin
               scl_pull  = 1'b1;
               bus_owned = 1'b1;
               done      = 1'b1;
               enter_phase(PH_IDLE);
            end
            PH_SP_REL: begin
               if (!sda) arb_lost = 1'b1;
               enter_phase(PH_SP_END);
            end
            PH_SP_END: begin
               bus_owned = 1'b0;
               done      = 1'b1;
               enter_phase(PH_IDLE);
            end
            PH_WR_HIGH: begin
               if (bit_idx < DATA_BITS) begin
                  if (shreg[BYTE_W-1] && !sda) arb_lost = 1'b1;
                  shreg = shreg << 1;
               end else begin
                  slave_ack = !sda;
               end
               done = finish_bit(PH_WR_LOW);
            end
            PH_RD_HIGH, PH_RN_HIGH: begin
               if (bit_idx < DATA_BITS) begin
                  shreg = {shreg[BYTE_W-2:0], sda};
               end else begin
                  // a NACK is a released SDA, so a low there is lost arbitration
                  if (bus_phase == PH_RN_HIGH && !sda) arb_lost = 1'b1;
                  last_read = shreg;
               end
               done = finish_bit(phase_type'(bus_phase - 5'd2));
            end
            default: enter_phase(phase_type'(bus_phase + 5'd1));
         endcase
      end
      beat.scl_drive_low    = scl_pull;
      beat.sda_drive_low    = sda_pull;
      beat.ready_res        = (bus_phase == PH_IDLE);
      beat.done_res         = done;
      beat.read_data        = last_read;
      beat.acked            = slave_ack;
      beat.arbitration_lost = arb_lost;
      beat.bus_started      = bus_owned;
      return beat;
   endfunction

   task automatic check_field(input string field, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      res_type want;
      if (reset) begin
         cfg_half      = HALF_RESET;
         cfg_stretch   = STRETCH_RESET;
         bus_phase     = PH_IDLE;
         bit_idx       = '0;
         shreg         = '0;
         hp_ticks      = '0;
         stretch_ticks = '0;
         last_read     = '0;
         bus_owned     = 1'b0;
         arb_lost      = 1'b0;
         slave_ack     = 1'b0;
         scl_pull      = 1'b0;
         sda_pull      = 1'b0;
         mismatch_count = 0;
         expected_status.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_HALF_PERIOD)
               cfg_half = csr_wdata;
            else if (csr_index == CSR_STRETCH)
               cfg_stretch = csr_wdata[STRETCH_W-1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               $error("result beat with no tick waiting for it");
               mismatch_count++;
            end else begin
               want = expected_status.pop_front();
               check_field("scl_drive_low", want.scl_drive_low, rsp_scl_drive_low);
               check_field("sda_drive_low", want.sda_drive_low, rsp_sda_drive_low);
               check_field("ready_res", want.ready_res, rsp_ready_res);
               check_field("done_res", want.done_res, rsp_done_res);
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("acked", want.acked, rsp_acked);
               check_field("arbitration_lost", want.arbitration_lost, rsp_arbitration_lost);
               check_field("bus_started", want.bus_started, rsp_bus_started);
            end
         end
         if (req_valid && !req_stall)
            expected_status.push_back(advance_bus_tick(req_command, req_write_data,
                                                       req_send_nack, req_scl_in,
                                                       req_sda_in));
      end
      open_results = expected_status.size();
   end

   final begin
      // nothing here: leftovers are reported by the top through open_results
   end

endmodule

// ===== tb/sv/i2c_master_bit_engine_tb.sv =====
// Top of the I2C master bit engine testbench: clock, reset, bus stimulus and verdict.
`timescale 1ns / 100ps

module i2c_master_bit_engine_tb;
   import i2cm_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [2:0]           req_command = CMD_NONE;
   logic [BYTE_W-1:0]    req_write_data = '0;
   logic                 req_send_nack = 1'b0;
   logic                 req_scl_in = 1'b1;
   logic                 req_sda_in = 1'b1;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_scl_drive_low;
   logic                 rsp_sda_drive_low;
   logic                 rsp_ready_res;
   logic                 rsp_done_res;
   logic [BYTE_W-1:0]    rsp_read_data;
   logic                 rsp_acked;
   logic                 rsp_arbitration_lost;
   logic                 rsp_bus_started;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_HALF_PERIOD;
   logic [HALF_W-1:0]    csr_wdata = '0;

   int unsigned mismatch_count;
   int unsigned open_results;

   int unsigned cycle_count = 0;
   int unsigned ticks_sent = 0;
   int unsigned issued_cmds = 0;
   int unsigned finished_cmds = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned busy_poke_pct = 10;
   int unsigned sda_low_pct = 0;
   int unsigned scl_low_left = 0;
   int unsigned stretch_now = STRETCH_RESET;

   int unsigned hold_left = 0;
   int unsigned holds_done = 0;
   int unsigned next_hold_at = 600;

   i2c_master_bit_engine i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_write_data       (req_write_data),
      .req_send_nack        (req_send_nack),
      .req_scl_in           (req_scl_in),
      .req_sda_in           (req_sda_in),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_scl_drive_low    (rsp_scl_drive_low),
      .rsp_sda_drive_low    (rsp_sda_drive_low),
      .rsp_ready_res        (rsp_ready_res),
      .rsp_done_res         (rsp_done_res),
      .rsp_read_data        (rsp_read_data),
      .rsp_acked            (rsp_acked),
      .rsp_arbitration_lost (rsp_arbitration_lost),
      .rsp_bus_started      (rsp_bus_started),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   i2cm_bus_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_write_data       (req_write_data),
      .req_send_nack        (req_send_nack),
      .req_scl_in           (req_scl_in),
      .req_sda_in           (req_sda_in),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_scl_drive_low    (rsp_scl_drive_low),
      .rsp_sda_drive_low    (rsp_sda_drive_low),
      .rsp_ready_res        (rsp_ready_res),
      .rsp_done_res         (rsp_done_res),
      .rsp_read_data        (rsp_read_data),
      .rsp_acked            (rsp_acked),
      .rsp_arbitration_lost (rsp_arbitration_lost),
      .rsp_bus_started      (rsp_bus_started),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .mismatch_count       (mismatch_count),
      .open_results         (open_results)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall && rsp_done_res)
         finished_cmds <= finished_cmds + 1;
   end

   // result side: random stall, plus a long hold-off now and then so the input backs up
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_done < 2 && ticks_sent >= next_hold_at) begin
         rsp_stall    <= 1'b1;
         hold_left    <= 120;
         holds_done   <= holds_done + 1;
         next_hold_at <= next_hold_at + 500;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("i2c_master_bit_engine_tb: done, errors");
      $finish;
   end

   // line levels for one tick: SCL mostly high with low runs that look like stretching
   task automatic bus_lines(output logic scl, output logic sda);
      int unsigned pick;
      pick = $urandom_range(399);
      if (scl_low_left == 0) begin
         if (pick == 0)
            scl_low_left = $urandom_range(stretch_now + 2, 1);
         else if (pick < 16)
            scl_low_left = $urandom_range(8, 1);
      end
      if (scl_low_left != 0) begin
         scl = 1'b0;
         scl_low_left--;
      end else begin
         scl = ($urandom_range(7) != 0);
      end
      sda = ($urandom_range(99) >= sda_low_pct);
   endtask

   // present one tick beat and hold it until it is taken
   task automatic offer_tick(input logic [2:0] cmd, input logic [BYTE_W-1:0] data,
                             input logic nack);
      logic scl;
      logic sda;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      bus_lines(scl, sda);
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_write_data <= data;
      req_send_nack  <= nack;
      req_scl_in     <= scl;
      req_sda_in     <= sda;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
      @(negedge clock);
   endtask

   // issue a command to the idle engine and tick until its done pulse comes back
   task automatic run_command(input logic [2:0] cmd, input logic [BYTE_W-1:0] data,
                              input logic nack);
      offer_tick(cmd, data, nack);
      issued_cmds++;
      // the engine is surely busy on the next tick, so a command there is dropped
      if ($urandom_range(99) < busy_poke_pct)
         offer_tick(3'($urandom_range(CMD_READ, CMD_START)), 8'($urandom), 1'($urandom));
      while (finished_cmds != issued_cmds)
         offer_tick(CMD_NONE, 8'($urandom), 1'($urandom));
   endtask

   task automatic write_timing(input logic [HALF_W-1:0] half,
                               input logic [STRETCH_W-1:0] stretch);
      req_valid <= 1'b0;
      while (open_results != 0) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_HALF_PERIOD;
      csr_wdata <= half;
      @(negedge clock);
      // upper bits of the write data are junk for the narrower register
      csr_index <= CSR_STRETCH;
      csr_wdata <= {6'($urandom), stretch};
      @(negedge clock);
      csr_write <= 1'b0;
      stretch_now = stretch;
   endtask

   task automatic random_transaction();
      int unsigned n_ops;
      logic        reading;
      sda_low_pct = ($urandom_range(3) == 0) ? 100 * $urandom_range(1) : $urandom_range(100);
      run_command(CMD_START, '0, 1'b0);
      run_command(CMD_WRITE, 8'($urandom), 1'($urandom));
      reading = 1'($urandom);
      n_ops = $urandom_range(3, 1);
      for (int unsigned i = 0; i < n_ops; i++) begin
         if (reading)
            run_command(CMD_READ, 8'($urandom), (i == n_ops - 1) || ($urandom_range(7) == 0));
         else
            run_command(CMD_WRITE, 8'($urandom), 1'($urandom));
      end
      if ($urandom_range(3) == 0) begin
         run_command(CMD_START, 8'($urandom), 1'($urandom));
         run_command(CMD_WRITE, 8'($urandom), 1'($urandom));
         run_command(CMD_READ, 8'($urandom), 1'b1);
      end
      if ($urandom_range(9) != 0)
         run_command(CMD_STOP, 8'($urandom), 1'($urandom));
   endtask

   task automatic random_traffic(input int unsigned goal);
      while (ticks_sent < goal) begin
         if ($urandom_range(99) < 80) begin
            random_transaction();
         end else begin
            sda_low_pct = $urandom_range(100);
            case ($urandom_range(2))
               0: offer_tick(3'($urandom_range(7, CMD_READ + 1)), 8'($urandom), 1'($urandom));
               1: repeat ($urandom_range(6, 1)) offer_tick(CMD_NONE, 8'($urandom), 1'($urandom));
               default: run_command(3'($urandom_range(CMD_READ, CMD_START)), 8'($urandom),
                                    1'($urandom));
            endcase
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 22;
      recv_idle_pct = 53;

      // one start at the reset timing
      sda_low_pct = 0;
      run_command(CMD_START, '0, 1'b0);

      // zero half period behaves as one tick, no stretch allowance
      write_timing('0, '0);
      offer_tick(3'(CMD_READ + 1), 8'hFF, 1'b1);
      offer_tick('1, 8'h00, 1'b0);
      busy_poke_pct = 100;
      run_command(CMD_START, 8'h00, 1'b0);
      busy_poke_pct = 10;
      run_command(CMD_WRITE, 8'hFF, 1'b0);
      sda_low_pct = 100;
      run_command(CMD_WRITE, 8'h00, 1'b1);
      run_command(CMD_WRITE, 8'hA5, 1'b0);
      run_command(CMD_READ, 8'hFF, 1'b1);
      sda_low_pct = 0;
      run_command(CMD_READ, 8'h00, 1'b0);
      sda_low_pct = 100;
      run_command(CMD_STOP, 8'h00, 1'b0);
      // bus not started: stop, write and read go out as they are
      run_command(CMD_STOP, 8'hFF, 1'b1);
      run_command(CMD_WRITE, 8'h5A, 1'b0);
      run_command(CMD_READ, 8'h3C, 1'b0);
      run_command(CMD_START, 8'h00, 1'b0);
      sda_low_pct = 0;
      run_command(CMD_STOP, 8'h00, 1'b0);

      random_traffic(950);
      write_timing(16'd2, 10'd5);
      random_traffic(1100);

      send_idle_pct = 53;
      recv_idle_pct = 22;
      write_timing(16'd3, 10'd1023);
      random_traffic(1250);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_timing(16'd1, 10'd3);
      random_traffic(1350);
      run_command(CMD_STOP, '0, 1'b0);
      // longer half period: one start from a free bus
      write_timing(16'd32, 10'd0);
      sda_low_pct = 50;
      run_command(CMD_START, '0, 1'b0);

      req_valid <= 1'b0;
      while (open_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (mismatch_count == 0)
         $display("i2c_master_bit_engine_tb: done, clean");
      else
         $display("i2c_master_bit_engine_tb: done, errors");
      $finish;
   end

endmodule
